// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UIEH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UIEH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/uieh_pkg.sv =====
// ----------------------------------------------------------------------------
// uieh_pkg
// Types, constants and helper functions of the IPv4/UDP header builder.
// ----------------------------------------------------------------------------
package uieh_pkg;

   // Number of path keys held in the peer table.
   localparam int PATH_KEYS = 256;
   localparam int IDX_W     = (PATH_KEYS > 1) ? $clog2(PATH_KEYS) : 1;
   localparam int KEY_W     = 8;

   localparam int IP_VERSION   = 4;
   localparam int IP_HDR_BYTES = 20;
   localparam int UDP_HDR_BYTES = 8;
   localparam int TTL_VALUE    = 250;
   localparam int PROTO_UDP    = 17;

   localparam logic [15:0] MAX_PAYLOAD    = 16'd65507;
   localparam logic [15:0] TOTAL_HDR_LEN  = 16'(IP_HDR_BYTES + UDP_HDR_BYTES);
   localparam logic [15:0] UDP_HDR_LEN    = 16'(UDP_HDR_BYTES);
   localparam logic [15:0] VER_IHL_WORD   = {4'(IP_VERSION), 4'(IP_HDR_BYTES / 4), 8'h00};
   localparam logic [15:0] TTL_PROTO_WORD = {8'(TTL_VALUE), 8'(PROTO_UDP)};
   localparam logic [15:0] PROTO_WORD     = 16'(PROTO_UDP);

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SELECTED_PATH = 2'd0,
      CSR_LOCAL_IP      = 2'd1,
      CSR_LOCAL_PORT    = 2'd2
   } uieh_csr_type;

   // Summary of a finished packet, handed from the accumulator to the pipeline.
   typedef struct packed {
      logic [15:0] count;
      logic [15:0] sum;
      logic        too_long;
   } uieh_pkt_type;

   // One header descriptor.
   typedef struct packed {
      logic [31:0] dest_ip;
      logic [15:0] dest_port;
      logic [15:0] total_length;
      logic [15:0] udp_length;
      logic [15:0] ip_checksum;
      logic [15:0] udp_checksum;
      logic        too_long;
   } uieh_rsp_type;

   // Ones'-complement fold of a 20-bit raw sum down to 16 bits.
   function automatic logic [15:0] fold16(input logic [19:0] raw);
      logic [16:0] s1;
      logic [16:0] s2;
      s1 = 17'(raw[15:0]) + 17'(raw[19:16]);
      s2 = 17'(s1[15:0]) + 17'(s1[16]);
      return s2[15:0] + 16'(s2[16]);
   endfunction

endpackage

// ===== rtl/uieh_channels.sv =====
// ----------------------------------------------------------------------------
// uieh_channels
// Valid/ready channel interfaces of the IPv4/UDP header builder.
// ----------------------------------------------------------------------------
interface uieh_req_chan_type;
   import uieh_pkg::*;
   logic             valid;
   logic             ready;
   logic             operation;
   logic [31:0]      learn_ip;
   logic [15:0]      learn_port;
   logic [KEY_W-1:0] learn_key;
   logic [7:0]       data_byte;
   logic             last_byte;

   modport source (output valid, operation, learn_ip, learn_port, learn_key,
                   data_byte, last_byte, input ready);
   modport sink   (input valid, operation, learn_ip, learn_port, learn_key,
                   data_byte, last_byte, output ready);
endinterface

interface uieh_rsp_chan_type;
   logic        valid;
   logic        ready;
   logic [31:0] dest_ip;
   logic [15:0] dest_port;
   logic [15:0] total_length;
   logic [15:0] udp_length;
   logic [15:0] ip_checksum;
   logic [15:0] udp_checksum;
   logic        too_long;

   modport source (output valid, dest_ip, dest_port, total_length, udp_length,
                   ip_checksum, udp_checksum, too_long, input ready);
   modport sink   (input valid, dest_ip, dest_port, total_length, udp_length,
                   ip_checksum, udp_checksum, too_long, output ready);
endinterface

interface uieh_csr_chan_type;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/uieh_peer_mem.sv =====
// ----------------------------------------------------------------------------
// uieh_peer_mem
// Peer table: synchronous memory of {ip, port} per path key, with a valid
// bit per entry so that entries never learned read as zero.
// ----------------------------------------------------------------------------
module uieh_peer_mem (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [uieh_pkg::IDX_W-1:0] wr_addr,
   input  logic [47:0]                wr_data,
   input  logic                       rd_en,
   input  logic [uieh_pkg::IDX_W-1:0] rd_addr,
   output logic [47:0]                rd_data
);
   import uieh_pkg::*;

   logic [47:0]          mem_ff [PATH_KEYS];
   logic [PATH_KEYS-1:0] entry_valid_ff;
   logic [47:0]          rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= entry_valid_ff[rd_addr];
         end
      end
   end

   // Reads and writes come from distinct items, so a read never meets a write
   // to the same entry in one cycle.
   assign rd_data = rd_valid_ff ? rd_data_ff : 48'd0;

endmodule

// ===== rtl/uieh_accum.sv =====
// ----------------------------------------------------------------------------
// uieh_accum
// Running ones'-complement sum and saturating byte count of the payload.
// ----------------------------------------------------------------------------
module uieh_accum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_en,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output uieh_pkg::uieh_pkt_type done
);
   import uieh_pkg::*;

   logic [15:0] sum_ff,   sum_in;
   logic [15:0] count_ff, count_in;
   logic        odd_ff,   odd_in;
   logic [7:0]  hold_ff,  hold_in;
   logic        ovf_ff,   ovf_in;

   logic [15:0] word;
   logic [16:0] sum_add;
   logic [15:0] sum_fold;
   logic        cnt_sat;
   logic [15:0] cnt_next;
   logic        ovf_next;

   // A byte without a partner yet forms the high half of a word; on the last
   // byte it is added with a zero low half.
   assign word     = odd_ff ? {hold_ff, data_byte} : {data_byte, 8'h00};
   assign sum_add  = 17'(sum_ff) + 17'(word);
   assign sum_fold = sum_add[15:0] + 16'(sum_add[16]);
   assign cnt_sat  = (count_ff >= MAX_PAYLOAD);
   assign cnt_next = cnt_sat ? count_ff : 16'(count_ff + 16'd1);
   assign ovf_next = ovf_ff | cnt_sat;

   assign done.count    = cnt_next;
   assign done.sum      = sum_fold;
   assign done.too_long = ovf_next;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      odd_in   = odd_ff;
      hold_in  = hold_ff;
      ovf_in   = ovf_ff;
      if (byte_en) begin
         if (last_byte) begin
            sum_in   = '0;
            count_in = '0;
            odd_in   = 1'b0;
            hold_in  = '0;
            ovf_in   = 1'b0;
         end else begin
            count_in = cnt_next;
            ovf_in   = ovf_next;
            if (odd_ff) begin
               sum_in  = sum_fold;
               odd_in  = 1'b0;
               hold_in = '0;
            end else begin
               odd_in  = 1'b1;
               hold_in = data_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         odd_ff   <= 1'b0;
         hold_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         odd_ff   <= odd_in;
         hold_ff  <= hold_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

// ===== rtl/uieh_csum_pipe.sv =====
// ----------------------------------------------------------------------------
// uieh_csum_pipe
// Four-stage pipeline from the peer lookup to the registered descriptor:
// lookup, address sum and lengths, raw header sums, fold and complement.
// ----------------------------------------------------------------------------
module uieh_csum_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  uieh_pkg::uieh_pkt_type pkt,
   input  logic                   path_ok,
   input  logic [47:0]            peer,
   input  logic [31:0]            local_ip,
   input  logic [15:0]            local_port,
   output logic                   out_valid,
   input  logic                   out_ready,
   output uieh_pkg::uieh_rsp_type out_data
);
   import uieh_pkg::*;

   logic ready1, ready2, ready3, ready4;

   // Stage 1: packet summary, peer data comes from the memory read register.
   logic         v1_ff;
   uieh_pkt_type pkt1_ff;
   logic         path_ok1_ff;

   // Stage 2.
   logic         v2_ff;
   logic [31:0]  dip2_ff;
   logic [15:0]  dport2_ff, tlen2_ff, ulen2_ff, psum2_ff;
   logic [17:0]  asum2_ff;
   logic         ovf2_ff;

   // Stage 3.
   logic         v3_ff;
   logic [31:0]  dip3_ff;
   logic [15:0]  dport3_ff, tlen3_ff, ulen3_ff;
   logic [19:0]  ipraw3_ff, udpraw3_ff;
   logic         ovf3_ff;

   // Stage 4: output register.
   logic         v4_ff;
   uieh_rsp_type rsp4_ff;

   logic [31:0]  dip_in;
   logic [15:0]  dport_in;
   logic [17:0]  asum_in;
   logic [19:0]  ipraw_in, udpraw_in;

   assign ready4   = !v4_ff || out_ready;
   assign ready3   = !v3_ff || ready4;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   assign dip_in   = path_ok1_ff ? peer[47:16] : 32'd0;
   assign dport_in = path_ok1_ff ? peer[15:0]  : 16'd0;
   assign asum_in  = 18'(local_ip[31:16]) + 18'(local_ip[15:0])
                   + 18'(dip_in[31:16]) + 18'(dip_in[15:0]);

   assign ipraw_in  = 20'(asum2_ff) + 20'(VER_IHL_WORD) + 20'(TTL_PROTO_WORD)
                    + 20'(tlen2_ff);
   assign udpraw_in = 20'(asum2_ff) + 20'(PROTO_WORD) + 20'(ulen2_ff) + 20'(ulen2_ff)
                    + 20'(local_port) + 20'(dport2_ff) + 20'(psum2_ff);

   always_ff @(posedge clock) begin
      if (in_valid && ready1) begin
         pkt1_ff     <= pkt;
         path_ok1_ff <= path_ok;
      end
      if (ready2) begin
         dip2_ff   <= dip_in;
         dport2_ff <= dport_in;
         asum2_ff  <= asum_in;
         tlen2_ff  <= 16'(pkt1_ff.count + TOTAL_HDR_LEN);
         ulen2_ff  <= 16'(pkt1_ff.count + UDP_HDR_LEN);
         psum2_ff  <= pkt1_ff.sum;
         ovf2_ff   <= pkt1_ff.too_long;
      end
      if (ready3) begin
         dip3_ff    <= dip2_ff;
         dport3_ff  <= dport2_ff;
         tlen3_ff   <= tlen2_ff;
         ulen3_ff   <= ulen2_ff;
         ipraw3_ff  <= ipraw_in;
         udpraw3_ff <= udpraw_in;
         ovf3_ff    <= ovf2_ff;
      end
      if (ready4) begin
         rsp4_ff.dest_ip      <= dip3_ff;
         rsp4_ff.dest_port    <= dport3_ff;
         rsp4_ff.total_length <= tlen3_ff;
         rsp4_ff.udp_length   <= ulen3_ff;
         rsp4_ff.ip_checksum  <= ~fold16(ipraw3_ff);
         rsp4_ff.udp_checksum <= ~fold16(udpraw3_ff);
         rsp4_ff.too_long     <= ovf3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= in_valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
         if (ready4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = rsp4_ff;

endmodule

// ===== rtl/udp_ip_encap_header_builder.sv =====
// A packet's descriptor passes the stage 1, 2 and 3 registers and is shown from stage 4.
// Throughput: one learn, byte or last byte per cycle while the checksum pipeline is ready.
// The peer table is one synchronous memory, written by learns and read once per packet.
// Stalls on the result side back up through the four-stage checksum pipeline.
// Reset clears the config registers, all valid bits and the packet accumulators at once.
// ----------------------------------------------------------------------------
// udp_ip_encap_header_builder
// Builds IPv4+UDP header descriptors from a learned peer table and a stream
// of payload bytes.
// ----------------------------------------------------------------------------
module udp_ip_encap_header_builder (
   input  logic                     clock,
   input  logic                     reset,
   uieh_req_chan_type.sink          req_ch,
   uieh_rsp_chan_type.source        rsp_ch,
   uieh_csr_chan_type.sink          csr_ch
);
   import uieh_pkg::*;

   logic [KEY_W-1:0] selected_path_ff;
   logic [31:0]      local_ip_ff;
   logic [15:0]      local_port_ff;

   logic         req_acc;
   logic         learn_en;
   logic         byte_en;
   logic         last_en;
   logic         learn_ok;
   logic         path_ok;
   logic         pipe_ready;
   logic [47:0]  peer_data;
   uieh_pkt_type pkt_done;
   uieh_rsp_type rsp_data;

   // Configuration registers.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         selected_path_ff <= '0;
         local_ip_ff      <= '0;
         local_port_ff    <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_SELECTED_PATH: selected_path_ff <= csr_ch.data[KEY_W-1:0];
            CSR_LOCAL_IP:      local_ip_ff      <= csr_ch.data;
            CSR_LOCAL_PORT:    local_port_ff    <= csr_ch.data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ch.ready = pipe_ready;
   assign req_acc      = req_ch.valid && pipe_ready;
   assign learn_ok     = ({1'b0, req_ch.learn_key} < (KEY_W + 1)'(PATH_KEYS));
   assign path_ok      = ({1'b0, selected_path_ff} < (KEY_W + 1)'(PATH_KEYS));
   assign learn_en     = req_acc && !req_ch.operation && learn_ok;
   assign byte_en      = req_acc && req_ch.operation;
   assign last_en      = byte_en && req_ch.last_byte;

   uieh_peer_mem u_peer_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (learn_en),
      .wr_addr (req_ch.learn_key[IDX_W-1:0]),
      .wr_data ({req_ch.learn_ip, req_ch.learn_port}),
      .rd_en   (last_en),
      .rd_addr (selected_path_ff[IDX_W-1:0]),
      .rd_data (peer_data)
   );

   uieh_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (byte_en),
      .data_byte (req_ch.data_byte),
      .last_byte (req_ch.last_byte),
      .done      (pkt_done)
   );

   uieh_csum_pipe u_csum_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (last_en),
      .in_ready   (pipe_ready),
      .pkt        (pkt_done),
      .path_ok    (path_ok),
      .peer       (peer_data),
      .local_ip   (local_ip_ff),
      .local_port (local_port_ff),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_data   (rsp_data)
   );

   assign rsp_ch.dest_ip      = rsp_data.dest_ip;
   assign rsp_ch.dest_port    = rsp_data.dest_port;
   assign rsp_ch.total_length = rsp_data.total_length;
   assign rsp_ch.udp_length   = rsp_data.udp_length;
   assign rsp_ch.ip_checksum  = rsp_data.ip_checksum;
   assign rsp_ch.udp_checksum = rsp_data.udp_checksum;
   assign rsp_ch.too_long     = rsp_data.too_long;

endmodule

// ===== rtl/uieh_checker.sv =====
// ----------------------------------------------------------------------------
// uieh_checker
// Port-level checks of the header builder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uieh_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] total_length,
   input logic [15:0] udp_length,
   input logic        too_long
);

   `UIEH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result item dropped while stalled")
   `UIEH_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "result valid straight after reset")
   `UIEH_ASSERT_SAME(a_sat_len, clock, reset, rsp_valid && too_long, (total_length == 16'd65535) && (udp_length == 16'd65515), "oversized packet without saturated lengths")
   `UIEH_ASSERT_SAME(a_len_gap, clock, reset, rsp_valid, total_length == 16'(udp_length + 16'd20), "IP and UDP lengths disagree")

endmodule

bind udp_ip_encap_header_builder uieh_checker u_uieh_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .total_length (rsp_ch.total_length),
   .udp_length   (rsp_ch.udp_length),
   .too_long     (rsp_ch.too_long)
);
